/* rtl/umpq_pkg.sv */
// Shared types, codes and defaults for the unsorted minimum-priority queue.
`default_nettype none

package umpq_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 16;

    // Fixed port field widths.
    localparam int OP_W     = 2;
    localparam int KEY_W    = 16;
    localparam int PRIO_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // Capacity limit register value after reset.
    localparam logic [COUNT_W-1:0] LIMIT_RST = 7'd64;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_EXTRACT  = 2'd1;
    localparam logic [OP_W-1:0] OP_DECREASE = 2'd2;
    localparam logic [OP_W-1:0] OP_CONTAINS = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HIGHER   = 3'd5;

    // Flags from the shared compare unit.
    typedef struct packed {
        logic key_eq;
        logic prio_lt;
    } t_cmp_res;

endpackage

`default_nettype wire

/* rtl/umpq_mem.sv */
// Slot storage: one write port and one registered read port.
`default_nettype none

module umpq_mem #(
    parameter int DEPTH = umpq_pkg::CAPACITY_DEF,
    parameter int WIDTH = umpq_pkg::KEY_BITS_DEF + umpq_pkg::PRIO_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with the data registered.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/umpq_cmp.sv */
// Shared compare unit: key equality and signed priority less-than.
`default_nettype none

module umpq_cmp #(
    parameter int KEY_BITS = umpq_pkg::KEY_BITS_DEF
) (
    input  wire logic        [KEY_BITS-1:0]        i_a_key,
    input  wire logic        [KEY_BITS-1:0]        i_b_key,
    input  wire logic signed [umpq_pkg::PRIO_W-1:0] i_a_prio,
    input  wire logic signed [umpq_pkg::PRIO_W-1:0] i_b_prio,
    output umpq_pkg::t_cmp_res                     o_res
);

    // One equality compare and one signed magnitude compare.
    always_comb begin
        o_res.key_eq  = (i_a_key == i_b_key);
        o_res.prio_lt = (i_a_prio < i_b_prio);
    end

endmodule

`default_nettype wire

/* rtl/unsorted_min_priority_queue.sv */
// From the accepting edge a full insert or an extract on an empty queue goes straight to the
// result state; every other request scans the stored entries, one slot per cycle through the
// single registered memory read port, and an extract then fetches and moves the last entry.
// A new request is taken only after the result register has been loaded for the last one.
// A stalled result holds the sequencer.
// Synchronous active-low reset empties the queue, sets the capacity limit to 64,
// and leaves slot contents undefined; no clearing pass is needed.
`default_nettype none

module unsorted_min_priority_queue #(
    parameter int CAPACITY = umpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = umpq_pkg::KEY_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Configuration write channel.
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic        [umpq_pkg::COUNT_W-1:0]  i_cfg_data,
    // Request channel.
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic        [umpq_pkg::OP_W-1:0]     i_op,
    input  wire logic        [umpq_pkg::KEY_W-1:0]    i_key,
    input  wire logic signed [umpq_pkg::PRIO_W-1:0]   i_priority_req,
    // Result channel.
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic             [umpq_pkg::STATUS_W-1:0] o_status,
    output logic             [umpq_pkg::KEY_W-1:0]    o_min_key,
    output logic                                      o_found,
    output logic                                      o_is_empty,
    output logic             [umpq_pkg::COUNT_W-1:0]  o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = KEY_BITS + umpq_pkg::PRIO_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_LAST = 3'd3;
    localparam logic [2:0] S_MOVE = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                           r_state, n_state;
    logic [umpq_pkg::OP_W-1:0]            r_op, n_op;
    logic [KEY_BITS-1:0]                  r_req_key, n_req_key;
    logic signed [umpq_pkg::PRIO_W-1:0]   r_req_prio, n_req_prio;
    logic [CW-1:0]                        r_iss, n_iss;
    logic                                 r_pv, n_pv;
    logic [AW-1:0]                        r_pidx, n_pidx;
    logic                                 r_hit, n_hit;
    logic [AW-1:0]                        r_pos, n_pos;
    logic signed [umpq_pkg::PRIO_W-1:0]   r_best_prio, n_best_prio;
    logic [KEY_BITS-1:0]                  r_best_key, n_best_key;
    logic [CW-1:0]                        r_count, n_count;
    logic [umpq_pkg::COUNT_W-1:0]         r_cfg_limit;
    logic [umpq_pkg::STATUS_W-1:0]        r_status, n_status;
    logic                                 r_found, n_found;
    logic [umpq_pkg::KEY_W-1:0]           r_min_key, n_min_key;

    logic                                 r_out_valid, n_out_valid;
    logic [umpq_pkg::STATUS_W-1:0]        r_out_status, n_out_status;
    logic [umpq_pkg::KEY_W-1:0]           r_out_min_key, n_out_min_key;
    logic                                 r_out_found, n_out_found;
    logic                                 r_out_is_empty, n_out_is_empty;
    logic [umpq_pkg::COUNT_W-1:0]         r_out_entry_count, n_out_entry_count;

    logic                                 mem_we;
    logic [AW-1:0]                        mem_wr_addr;
    logic [DW-1:0]                        mem_wr_data;
    logic [AW-1:0]                        mem_rd_addr;
    logic [DW-1:0]                        mem_rd_data;
    logic [KEY_BITS-1:0]                  rd_key;
    logic signed [umpq_pkg::PRIO_W-1:0]   rd_prio;

    logic [KEY_BITS-1:0]                  cmp_a_key;
    logic signed [umpq_pkg::PRIO_W-1:0]   cmp_a_prio;
    logic signed [umpq_pkg::PRIO_W-1:0]   cmp_b_prio;
    umpq_pkg::t_cmp_res                   cmp_res;

    logic [31:0]                          key_ext;
    logic [KEY_BITS-1:0]                  in_key;
    logic [31:0]                          best_key_ext;
    logic [31:0]                          count_ext;
    logic [31:0]                          limit_ext;
    logic                                 is_full;
    logic [CW-1:0]                        count_m1;

    // Slot storage and the shared compare unit.
    umpq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    umpq_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .i_a_key  (cmp_a_key),
        .i_b_key  (r_req_key),
        .i_a_prio (cmp_a_prio),
        .i_b_prio (cmp_b_prio),
        .o_res    (cmp_res)
    );

    assign rd_key  = mem_rd_data[DW-1:umpq_pkg::PRIO_W];
    assign rd_prio = $signed(mem_rd_data[umpq_pkg::PRIO_W-1:0]);

    // Keys are compared on their low KEY_BITS bits.
    assign key_ext      = {16'd0, i_key};
    assign in_key       = key_ext[KEY_BITS-1:0];
    assign best_key_ext = 32'(r_best_key);

    // Insert is refused once the count reaches the limit or the capacity.
    assign count_ext = 32'(r_count);
    assign limit_ext = 32'(r_cfg_limit);
    assign is_full   = (count_ext >= limit_ext) || (count_ext >= 32'(CAPACITY));
    assign count_m1  = r_count - CW'(1);

    // Compare operands: scanned slot against the best or the request, or the
    // matched priority against the request when judging a decrease.
    always_comb begin
        cmp_a_key = rd_key;
        if (r_state == S_EVAL) begin
            cmp_a_prio = r_best_prio;
            cmp_b_prio = r_req_prio;
        end else begin
            cmp_a_prio = rd_prio;
            cmp_b_prio = (r_op == umpq_pkg::OP_EXTRACT) ? r_best_prio : r_req_prio;
        end
    end

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);

    // Sequencer.
    always_comb begin
        n_state           = r_state;
        n_op              = r_op;
        n_req_key         = r_req_key;
        n_req_prio        = r_req_prio;
        n_iss             = r_iss;
        n_pv              = r_pv;
        n_pidx            = r_pidx;
        n_hit             = r_hit;
        n_pos             = r_pos;
        n_best_prio       = r_best_prio;
        n_best_key        = r_best_key;
        n_count           = r_count;
        n_status          = r_status;
        n_found           = r_found;
        n_min_key         = r_min_key;
        n_out_valid       = r_out_valid & i_out_stall;
        n_out_status      = r_out_status;
        n_out_min_key     = r_out_min_key;
        n_out_found       = r_out_found;
        n_out_is_empty    = r_out_is_empty;
        n_out_entry_count = r_out_entry_count;
        mem_we            = 1'b0;
        mem_wr_addr       = r_count[AW-1:0];
        mem_wr_data       = {r_req_key, r_req_prio};
        mem_rd_addr       = r_iss[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                // Take a request and settle the early rejections.
                if (i_in_valid) begin
                    n_op       = i_op;
                    n_req_key  = in_key;
                    n_req_prio = i_priority_req;
                    n_iss      = '0;
                    n_pv       = 1'b0;
                    n_hit      = 1'b0;
                    n_found    = 1'b0;
                    n_min_key  = '0;
                    n_status   = umpq_pkg::ST_OK;
                    n_state    = S_SCAN;
                    if (i_op == umpq_pkg::OP_INSERT && is_full) begin
                        n_status = umpq_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else if (i_op == umpq_pkg::OP_EXTRACT && r_count == '0) begin
                        n_status = umpq_pkg::ST_EMPTY;
                        n_state  = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                // Issue one slot read per cycle.
                if (r_iss < r_count) begin
                    n_iss  = r_iss + CW'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_iss[AW-1:0];
                end else begin
                    n_pv = 1'b0;
                end
                // Examine the slot read in the previous cycle.
                if (r_pv) begin
                    if (r_op == umpq_pkg::OP_EXTRACT) begin
                        if (r_pidx == '0 || cmp_res.prio_lt) begin
                            n_best_prio = rd_prio;
                            n_best_key  = rd_key;
                            n_pos       = r_pidx;
                        end
                    end else if (cmp_res.key_eq && !r_hit) begin
                        n_hit       = 1'b1;
                        n_pos       = r_pidx;
                        n_best_prio = rd_prio;
                    end
                end
                if (r_iss == r_count && !r_pv) begin
                    n_state = (r_op == umpq_pkg::OP_EXTRACT) ? S_LAST : S_EVAL;
                end
            end
            S_LAST: begin
                // Fetch the last entry to fill the freed slot.
                mem_rd_addr = count_m1[AW-1:0];
                n_state     = S_MOVE;
            end
            S_MOVE: begin
                mem_we      = 1'b1;
                mem_wr_addr = r_pos;
                mem_wr_data = mem_rd_data;
                n_count     = count_m1;
                n_min_key   = best_key_ext[umpq_pkg::KEY_W-1:0];
                n_state     = S_DONE;
            end
            S_EVAL: begin
                // Finish insert, decrease and contains after the key search.
                unique case (r_op)
                    umpq_pkg::OP_INSERT: begin
                        if (r_hit) begin
                            n_status = umpq_pkg::ST_DUP;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    umpq_pkg::OP_DECREASE: begin
                        if (!r_hit) begin
                            n_status = umpq_pkg::ST_NOTFOUND;
                        end else if (cmp_res.prio_lt) begin
                            n_status = umpq_pkg::ST_HIGHER;
                        end else begin
                            mem_we      = 1'b1;
                            mem_wr_addr = r_pos;
                        end
                    end
                    umpq_pkg::OP_CONTAINS: begin
                        n_found = r_hit;
                    end
                    default: begin
                        n_status = r_status;
                    end
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                // Load the result register once it is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out_status      = r_status;
                    n_out_min_key     = r_min_key;
                    n_out_found       = r_found;
                    n_out_is_empty    = (r_count == '0);
                    n_out_entry_count = count_ext[umpq_pkg::COUNT_W-1:0];
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_limit <= umpq_pkg::LIMIT_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_limit <= i_cfg_data;
            end
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_op              <= n_op;
        r_req_key         <= n_req_key;
        r_req_prio        <= n_req_prio;
        r_iss             <= n_iss;
        r_pidx            <= n_pidx;
        r_hit             <= n_hit;
        r_pos             <= n_pos;
        r_best_prio       <= n_best_prio;
        r_best_key        <= n_best_key;
        r_status          <= n_status;
        r_found           <= n_found;
        r_min_key         <= n_min_key;
        r_out_status      <= n_out_status;
        r_out_min_key     <= n_out_min_key;
        r_out_found       <= n_out_found;
        r_out_is_empty    <= n_out_is_empty;
        r_out_entry_count <= n_out_entry_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_min_key     = r_out_min_key;
    assign o_found       = r_out_found;
    assign o_is_empty    = r_out_is_empty;
    assign o_entry_count = r_out_entry_count;

    // The count never passes the capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(CAPACITY))
        else $error("entry count above capacity");

    // A new result appears only from the result state.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state) == S_DONE)
        else $error("result loaded outside the result state");

    // Moving the last entry shrinks the queue by one.
    a_move_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |=> r_count == $past(count_m1))
        else $error("extract did not shrink the count");

    // Scanned slots are always below the count.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pv) |-> 32'(r_pidx) < count_ext)
        else $error("scan read beyond stored entries");

    // The count changes by at most one per cycle.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1) || r_count == $past(r_count) - CW'(1)))
        else $error("entry count jumped");

endmodule

`default_nettype wire
